>>> design/cfdw_pkg.sv
// ----------------------------------------------------------------------------
// cfdw_pkg
// Shared types, constants and helper functions of the complex feedback
// delay wah.
// ----------------------------------------------------------------------------
package cfdw_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int PHASE_W    = 32;
    localparam int FB_W       = 17;
    localparam int LEN_W      = 7;
    localparam int COEF_W     = 18;
    localparam int GAIN_W     = 18;
    localparam int ENTRY_W    = 24;
    localparam int OPND_W     = 36;
    localparam int PROD_W     = 72;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [PHASE_W-1:0]       PI_Q30  = 32'd3373259426;
    localparam logic signed [OPND_W-1:0] ONE_Q30 = 36'sd1073741824;
    localparam logic signed [OPND_W-1:0] TWO_Q30 = 36'sd2147483648;
    localparam logic [GAIN_W-1:0]        G_BASE  = 18'd96993;
    localparam logic [GAIN_W-1:0]        ONE_Q17 = 18'd131072;
    localparam logic [FB_W-1:0]          FB_MAX  = 17'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_STEP   = 2'd0,
        CFG_START_PHASE  = 2'd1,
        CFG_FEEDBACK     = 2'd2,
        CFG_DELAY_LENGTH = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x;
        logic                       upd;
        logic [PHASE_W-1:0]         phase;
    } t_item;

    typedef struct packed {
        logic               start;
        logic [PHASE_W-1:0] phase;
    } t_coef_req;

    typedef struct packed {
        logic                     busy;
        logic signed [COEF_W-1:0] cr;
        logic signed [COEF_W-1:0] ci;
    } t_coef_rsp;

    function automatic logic signed [OPND_W-1:0] trunc30(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] v;
        v = (p < 0) ? (p + 72'sd1073741823) : p;
        v = v >>> 30;
        return v[OPND_W-1:0];
    endfunction

    function automatic logic [8:0] divisor(input logic [4:0] k);
        logic [8:0] d;
        case (k)
            5'd2:    d = 9'd2;
            5'd3:    d = 9'd6;
            5'd4:    d = 9'd12;
            5'd5:    d = 9'd20;
            5'd6:    d = 9'd30;
            5'd7:    d = 9'd42;
            5'd8:    d = 9'd56;
            5'd9:    d = 9'd72;
            5'd10:   d = 9'd90;
            5'd11:   d = 9'd110;
            5'd12:   d = 9'd132;
            5'd13:   d = 9'd156;
            5'd14:   d = 9'd182;
            5'd15:   d = 9'd210;
            5'd16:   d = 9'd240;
            5'd17:   d = 9'd272;
            default: d = 9'd2;
        endcase
        return d;
    endfunction

    // floor(2^33 / divisor(k))
    function automatic logic [32:0] recip(input logic [4:0] k);
        logic [32:0] m;
        case (k)
            5'd2:    m = 33'd4294967296;
            5'd3:    m = 33'd1431655765;
            5'd4:    m = 33'd715827882;
            5'd5:    m = 33'd429496729;
            5'd6:    m = 33'd286331153;
            5'd7:    m = 33'd204522252;
            5'd8:    m = 33'd153391689;
            5'd9:    m = 33'd119304647;
            5'd10:   m = 33'd95443717;
            5'd11:   m = 33'd78090314;
            5'd12:   m = 33'd65075262;
            5'd13:   m = 33'd55063683;
            5'd14:   m = 33'd47197442;
            5'd15:   m = 33'd40904450;
            5'd16:   m = 33'd35791394;
            5'd17:   m = 33'd31580641;
            default: m = 33'd4294967296;
        endcase
        return m;
    endfunction

endpackage

>>> design/cfdw_front.sv
// ----------------------------------------------------------------------------
// cfdw_front
// Accepts input samples, advances the LFO phase and marks the samples that
// reload the coefficient.
// ----------------------------------------------------------------------------
module cfdw_front #(
    parameter int LFO_INTERVAL = 25
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [cfdw_pkg::SAMPLE_W-1:0] i_sample_in,
    input  logic [cfdw_pkg::PHASE_W-1:0]         i_phase_step,
    input  logic [cfdw_pkg::PHASE_W-1:0]         i_start_phase,
    input  logic                                i_full,
    output logic                                o_push,
    output cfdw_pkg::t_item                     o_item
);
    import cfdw_pkg::*;

    localparam int CW = (LFO_INTERVAL > 1) ? $clog2(LFO_INTERVAL) : 1;

    logic [PHASE_W-1:0] r_acc;
    logic [CW-1:0]      r_cnt;
    logic [PHASE_W-1:0] w_acc;

    assign w_acc        = r_acc + i_phase_step;
    assign o_ready      = !i_full;
    assign o_push       = i_valid && !i_full;
    assign o_item.x     = i_sample_in;
    assign o_item.upd   = (r_cnt == '0);
    assign o_item.phase = w_acc + i_start_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_cnt <= '0;
        end else if (o_push) begin
            r_acc <= w_acc;
            if (r_cnt == '0) begin
                r_cnt <= CW'(LFO_INTERVAL - 1);
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> design/cfdw_queue.sv
// ----------------------------------------------------------------------------
// cfdw_queue
// Two-entry request queue between the front and the back.
// ----------------------------------------------------------------------------
module cfdw_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cfdw_pkg::t_item i_item,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_pop,
    output cfdw_pkg::t_item o_item
);
    import cfdw_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_item        r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> design/cfdw_coef.sv
// ----------------------------------------------------------------------------
// cfdw_coef
// Coefficient unit: LFO cosine, angle, and g*(cos a, sin a) through Taylor
// series on one shared multiplier; constant divisions use reciprocal
// multiplication with a one-step correction.
// ----------------------------------------------------------------------------
module cfdw_coef (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cfdw_pkg::t_coef_req               i_req,
    input  logic [cfdw_pkg::GAIN_W-1:0]       i_gain,
    output cfdw_pkg::t_coef_rsp               o_rsp
);
    import cfdw_pkg::*;

    typedef enum logic [14:0] {
        S_IDLE = 15'b000000000000001,
        S_X1   = 15'b000000000000010,
        S_X2   = 15'b000000000000100,
        S_Q1   = 15'b000000000001000,
        S_Q2   = 15'b000000000010000,
        S_DIV  = 15'b000000000100000,
        S_DQ   = 15'b000000001000000,
        S_DC   = 15'b000000010000000,
        S_T1   = 15'b000000100000000,
        S_T2   = 15'b000001000000000,
        S_S1   = 15'b000010000000000,
        S_S2   = 15'b000100000000000,
        S_FIN  = 15'b001000000000000,
        S_G1   = 15'b010000000000000,
        S_G2   = 15'b100000000000000
    } t_state;

    typedef enum logic [2:0] {
        SER_LFO  = 3'b001,
        SER_COSA = 3'b010,
        SER_SINA = 3'b100
    } t_series;

    t_state  r_state;
    t_series r_ser;

    logic signed [OPND_W-1:0] r_ma;
    logic signed [OPND_W-1:0] r_mb;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [OPND_W-1:0] r_x;
    logic signed [OPND_W-1:0] r_x2;
    logic signed [OPND_W-1:0] r_t;
    logic [4:0]               r_k;
    logic                     r_sin;
    logic [1:0]               r_q;
    logic signed [COEF_W-1:0] r_cr;
    logic signed [COEF_W-1:0] r_ci;

    logic [OPND_W-1:0] r_quo;
    logic [8:0]        r_dsor;
    logic [44:0]       w_qd;
    logic              w_qinc;

    logic signed [OPND_W-1:0] w_tr;
    logic signed [OPND_W-1:0] w_tnew;
    logic signed [OPND_W-1:0] w_cv;
    logic signed [OPND_W-1:0] w_a;
    logic [4:0]               w_k2;

    assign o_rsp.busy = (r_state != S_IDLE);
    assign o_rsp.cr   = r_cr;
    assign o_rsp.ci   = r_ci;

    assign w_tr   = trunc30(r_prod);
    assign w_tnew = ONE_Q30 - w_tr;
    assign w_k2   = r_k - 5'd2;

    assign w_qd   = 45'(r_quo) * 45'(r_dsor);
    assign w_qinc = ((45'(r_x2) - w_qd) >= 45'(r_dsor));

    always_comb begin
        case (r_q)
            2'd1, 2'd2: w_cv = -r_t;
            default:    w_cv = r_t;
        endcase
        w_a = ONE_Q30 + w_cv;
        if (w_a < 0) begin
            w_a = '0;
        end else if (w_a > TWO_Q30) begin
            w_a = TWO_Q30;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(r_ma) * PROD_W'(r_mb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ser   <= SER_LFO;
            r_cr    <= '0;
            r_ci    <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_q     <= i_req.phase[31:30];
                        r_ma    <= OPND_W'({1'b0, i_req.phase[29:0]});
                        r_mb    <= OPND_W'({1'b0, PI_Q30});
                        r_ser   <= SER_LFO;
                        r_state <= S_X1;
                    end
                end
                S_X1: begin
                    r_state <= S_X2;
                end
                S_X2: begin
                    r_x     <= OPND_W'(r_prod >>> 31);
                    r_ma    <= OPND_W'(r_prod >>> 31);
                    r_mb    <= OPND_W'(r_prod >>> 31);
                    r_sin   <= r_q[0];
                    r_state <= S_Q1;
                end
                S_Q1: begin
                    r_state <= S_Q2;
                end
                S_Q2: begin
                    r_x2    <= OPND_W'(r_prod >>> 30);
                    r_t     <= ONE_Q30;
                    r_k     <= r_sin ? 5'd17 : 5'd16;
                    r_ma    <= OPND_W'(r_prod >>> 30);
                    r_mb    <= OPND_W'(recip(r_sin ? 5'd17 : 5'd16));
                    r_dsor  <= divisor(r_sin ? 5'd17 : 5'd16);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_state <= S_DQ;
                end
                S_DQ: begin
                    r_quo   <= OPND_W'(r_prod >>> 33);
                    r_state <= S_DC;
                end
                S_DC: begin
                    r_ma    <= signed'(w_qinc ? (r_quo + 1'b1) : r_quo);
                    r_mb    <= r_t;
                    r_state <= S_T1;
                end
                S_T1: begin
                    r_state <= S_T2;
                end
                S_T2: begin
                    r_t <= w_tnew;
                    if (w_k2 < 5'd2) begin
                        if (r_sin) begin
                            r_ma    <= r_x;
                            r_mb    <= w_tnew;
                            r_state <= S_S1;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end else begin
                        r_k     <= w_k2;
                        r_ma    <= r_x2;
                        r_mb    <= OPND_W'(recip(w_k2));
                        r_dsor  <= divisor(w_k2);
                        r_state <= S_DIV;
                    end
                end
                S_S1: begin
                    r_state <= S_S2;
                end
                S_S2: begin
                    r_t     <= w_tr;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    case (r_ser)
                        SER_LFO: begin
                            r_x     <= w_a;
                            r_ma    <= w_a;
                            r_mb    <= w_a;
                            r_sin   <= 1'b0;
                            r_ser   <= SER_COSA;
                            r_state <= S_Q1;
                        end
                        default: begin
                            r_ma    <= OPND_W'({1'b0, i_gain});
                            r_mb    <= r_t;
                            r_state <= S_G1;
                        end
                    endcase
                end
                S_G1: begin
                    r_state <= S_G2;
                end
                S_G2: begin
                    if (r_ser == SER_COSA) begin
                        r_cr    <= COEF_W'(w_tr);
                        r_ma    <= r_x;
                        r_mb    <= r_x;
                        r_sin   <= 1'b1;
                        r_ser   <= SER_SINA;
                        r_state <= S_Q1;
                    end else begin
                        r_ci    <= COEF_W'(w_tr);
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> design/cfdw_back.sv
// ----------------------------------------------------------------------------
// cfdw_back
// Delay line, complex multiply-accumulate and output register.
// ----------------------------------------------------------------------------
module cfdw_back #(
    parameter int MAX_DELAY = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_qvalid,
    output logic                             o_pop,
    input  cfdw_pkg::t_item                  i_item,
    input  logic [cfdw_pkg::GAIN_W-1:0]      i_gain,
    input  logic [cfdw_pkg::LEN_W-1:0]       i_delay_length,
    output cfdw_pkg::t_coef_req              o_creq,
    input  cfdw_pkg::t_coef_rsp              i_crsp,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [cfdw_pkg::SAMPLE_W-1:0] o_sample_out
);
    import cfdw_pkg::*;

    localparam int AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;

    typedef enum logic [5:0] {
        B_IDLE = 6'b000001,
        B_COEF = 6'b000010,
        B_READ = 6'b000100,
        B_MUL  = 6'b001000,
        B_SUM  = 6'b010000,
        B_OUT  = 6'b100000
    } t_state;

    t_state r_state;

    logic [2*ENTRY_W-1:0] r_mem [MAX_DELAY];
    logic [MAX_DELAY-1:0] r_vld;
    logic [2*ENTRY_W-1:0] r_rd;
    logic                 r_rdv;
    logic [AW-1:0]        r_k;

    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [41:0]         r_p_rr;
    logic signed [41:0]         r_p_ii;
    logic signed [41:0]         r_p_ri;
    logic signed [41:0]         r_p_ir;
    logic signed [34:0]         r_p_gx;
    logic signed [ENTRY_W-1:0]  r_re;
    logic signed [ENTRY_W-1:0]  r_im;
    logic                       r_ovalid;
    logic signed [SAMPLE_W-1:0] r_out;

    logic signed [ENTRY_W-1:0] w_dr;
    logic signed [ENTRY_W-1:0] w_di;
    logic signed [47:0]        w_sre;
    logic signed [47:0]        w_sim;
    logic signed [47:0]        w_tre;
    logic signed [47:0]        w_tim;
    logic signed [ENTRY_W-1:0] w_re;
    logic signed [ENTRY_W-1:0] w_im;
    logic signed [25:0]        w_re3;
    logic signed [25:0]        w_o;
    logic signed [SAMPLE_W-1:0] w_out;
    logic [AW:0]               w_len;
    logic [AW:0]               w_k1;
    logic [AW-1:0]             w_knext;
    logic                      w_load;

    assign o_pop        = (r_state == B_IDLE) && i_qvalid;
    assign o_creq.start = o_pop && i_item.upd;
    assign o_creq.phase = i_item.phase;
    assign o_valid      = r_ovalid;
    assign o_sample_out = r_out;
    assign w_load       = (r_state == B_OUT) && (!r_ovalid || i_ready);

    assign w_dr = r_rdv ? r_rd[2*ENTRY_W-1:ENTRY_W] : '0;
    assign w_di = r_rdv ? r_rd[ENTRY_W-1:0] : '0;

    always_comb begin
        w_sre = 48'(r_p_rr) - 48'(r_p_ii) + (48'(r_p_gx) <<< 7);
        w_sim = 48'(r_p_ri) + 48'(r_p_ir);
        w_tre = ((w_sre < 0) ? (w_sre + 48'sd131071) : w_sre) >>> 17;
        w_tim = ((w_sim < 0) ? (w_sim + 48'sd131071) : w_sim) >>> 17;
        if (w_tre > 48'sd8388607) begin
            w_re = 24'sd8388607;
        end else if (w_tre < -48'sd8388608) begin
            w_re = -24'sd8388608;
        end else begin
            w_re = w_tre[ENTRY_W-1:0];
        end
        if (w_tim > 48'sd8388607) begin
            w_im = 24'sd8388607;
        end else if (w_tim < -48'sd8388608) begin
            w_im = -24'sd8388608;
        end else begin
            w_im = w_tim[ENTRY_W-1:0];
        end
    end

    always_comb begin
        w_re3 = (26'(r_re) <<< 1) + 26'(r_re);
        w_o   = ((w_re3 < 0) ? (w_re3 + 26'sd127) : w_re3) >>> 7;
        if (w_o > 26'sd32767) begin
            w_out = 16'sd32767;
        end else if (w_o < -26'sd32768) begin
            w_out = -16'sd32768;
        end else begin
            w_out = w_o[SAMPLE_W-1:0];
        end
    end

    always_comb begin
        if (i_delay_length == '0) begin
            w_len = (AW+1)'(1);
        end else if (int'(i_delay_length) > MAX_DELAY) begin
            w_len = (AW+1)'(MAX_DELAY);
        end else begin
            w_len = (AW+1)'(i_delay_length);
        end
        w_k1 = {1'b0, r_k} + 1'b1;
        w_knext = (w_k1 >= w_len) ? '0 : w_k1[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_k];
        if (w_load) begin
            r_mem[r_k] <= {r_re, r_im};
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_x <= i_item.x;
        end
        if (r_state == B_READ) begin
            r_rdv <= r_vld[r_k];
        end
        if (r_state == B_MUL) begin
            r_p_rr <= 42'(i_crsp.cr) * 42'(w_dr);
            r_p_ii <= 42'(i_crsp.ci) * 42'(w_di);
            r_p_ri <= 42'(i_crsp.cr) * 42'(w_di);
            r_p_ir <= 42'(i_crsp.ci) * 42'(w_dr);
            r_p_gx <= 35'(signed'({1'b0, ONE_Q17 - i_gain})) * 35'(r_x);
        end
        if (r_state == B_SUM) begin
            r_re <= w_re;
            r_im <= w_im;
        end
        if (w_load) begin
            r_out <= w_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_vld    <= '0;
            r_k      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_load) begin
                r_ovalid   <= 1'b1;
                r_vld[r_k] <= 1'b1;
                r_k        <= w_knext;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (i_qvalid) begin
                        r_state <= i_item.upd ? B_COEF : B_READ;
                    end
                end
                B_COEF: begin
                    if (!i_crsp.busy) begin
                        r_state <= B_READ;
                    end
                end
                B_READ: begin
                    r_state <= B_MUL;
                end
                B_MUL: begin
                    r_state <= B_SUM;
                end
                B_SUM: begin
                    r_state <= B_OUT;
                end
                B_OUT: begin
                    if (w_load) begin
                        r_state <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

endmodule

>>> design/complex_feedback_delay_wah.sv
// ----------------------------------------------------------------------------
// complex_feedback_delay_wah
// Complex feedback delay wah: one 16-bit sample in, one sample out.
// ----------------------------------------------------------------------------
// In the back end a sample passes through queue pop, delay line read,
// complex multiply, sum and saturate, and output load; the two-entry
// queue lets new samples enter while earlier ones are processed or their
// results wait. Every LFO_INTERVAL-th sample, starting with the first,
// first waits for the coefficient unit, whose single shared multiplier
// runs three Taylor series, each term divided by reciprocal
// multiplication.
// The delay line needs no clearing pass: a valid bit per entry makes an
// unwritten entry read as zero. Configuration writes are always accepted.
module complex_feedback_delay_wah #(
    parameter int MAX_DELAY    = 64,
    parameter int LFO_INTERVAL = 25
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [cfdw_pkg::SAMPLE_W-1:0] i_sample_in,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [cfdw_pkg::SAMPLE_W-1:0] o_sample_out,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [cfdw_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [cfdw_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import cfdw_pkg::*;

    logic [PHASE_W-1:0] r_phase_step;
    logic [PHASE_W-1:0] r_start_phase;
    logic [FB_W-1:0]    r_feedback;
    logic [LEN_W-1:0]   r_delay_length;

    logic [FB_W-1:0]   w_fb;
    logic [GAIN_W-1:0] w_gain;
    logic              w_push;
    logic              w_full;
    logic              w_qvalid;
    logic              w_pop;
    t_item             w_fitem;
    t_item             w_qitem;
    t_coef_req         w_creq;
    t_coef_rsp         w_crsp;

    assign o_cfg_ready = 1'b1;
    assign w_fb   = (r_feedback > FB_MAX) ? FB_MAX : r_feedback;
    assign w_gain = GAIN_W'(w_fb[FB_W-1:1]) + G_BASE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step   <= 32'd58434;
            r_start_phase  <= '0;
            r_feedback     <= 17'd32768;
            r_delay_length <= 7'd20;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PHASE_STEP:   r_phase_step   <= i_cfg_data;
                CFG_START_PHASE:  r_start_phase  <= i_cfg_data;
                CFG_FEEDBACK:     r_feedback     <= i_cfg_data[FB_W-1:0];
                CFG_DELAY_LENGTH: r_delay_length <= i_cfg_data[LEN_W-1:0];
                default:          r_feedback     <= r_feedback;
            endcase
        end
    end

    cfdw_front #(
        .LFO_INTERVAL (LFO_INTERVAL)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_sample_in   (i_sample_in),
        .i_phase_step  (r_phase_step),
        .i_start_phase (r_start_phase),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_item        (w_fitem)
    );

    cfdw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_fitem),
        .o_full  (w_full),
        .o_valid (w_qvalid),
        .i_pop   (w_pop),
        .o_item  (w_qitem)
    );

    cfdw_coef u_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_creq),
        .i_gain  (w_gain),
        .o_rsp   (w_crsp)
    );

    cfdw_back #(
        .MAX_DELAY (MAX_DELAY)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_qvalid       (w_qvalid),
        .o_pop          (w_pop),
        .i_item         (w_qitem),
        .i_gain         (w_gain),
        .i_delay_length (r_delay_length),
        .o_creq         (w_creq),
        .i_crsp         (w_crsp),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_sample_out   (o_sample_out)
    );

endmodule

>>> design/cfdw_checker.sv
// ----------------------------------------------------------------------------
// cfdw_checker
// Port-level checks of the complex feedback delay wah, bound to the top.
// ----------------------------------------------------------------------------
module cfdw_props (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_sample_out
);
    logic [2:0] r_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if ((i_valid && o_ready) && !(o_valid && i_ready)) begin
            r_pend <= r_pend + 1'b1;
        end else if (!(i_valid && o_ready) && (o_valid && i_ready)) begin
            r_pend <= r_pend - 1'b1;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_sample_out))
        else $error("result dropped or changed while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_pend != 3'd0)
        else $error("result without pending request");

    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= 3'd4)
        else $error("too many requests in flight");

endmodule

bind complex_feedback_delay_wah cfdw_props u_chk (.*);
